>>> src/kc2d_pkg.sv
// ----------------------------------------------------------------------------
// kc2d_pkg
// Shared widths, register indexes and reset values for the 2-D convolution.
// ----------------------------------------------------------------------------
package kc2d_pkg;

    // Image geometry and counters
    localparam int DIM_W = 10;   // width and height registers
    localparam int CNT_W = 21;   // items counted in one frame, including the drain
    localparam int PIX_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 50;
    localparam int COEF_PAIR_W = 50;   // two kernel rows
    localparam int COEF_ROW_W  = 25;   // one kernel row
    localparam int COEF_SPAN_W = 64;   // coefficient bits that are looked at

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_LARGE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROWS_TOP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROWS_MID   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_BOTTOM = 3'd5;

    localparam int IMAGE_WIDTH_RESET  = 512;
    localparam int IMAGE_HEIGHT_RESET = 512;

    // Parameter defaults
    localparam int DEFAULT_MAX_WIDTH  = 512;
    localparam int DEFAULT_MAX_KERNEL = 5;
    localparam int DEFAULT_COEF_BITS  = 5;

    // Division by sixteen
    localparam int DIV_SHIFT = 4;

endpackage

>>> src/kernel_convolution_2d_top.sv
// ----------------------------------------------------------------------------
// kernel_convolution_2d_top
// Streaming 3x3 / 5x5 image convolution with zero padding at the frame edges.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock, and the block keeps that rate
// indefinitely while m_axis_tready is high: each cycle one pixel can be taken
// and one result given. A result leaves once the bottom-right pixel of its
// window has entered, that is h*W+h items after its own pixel (h is 1 for
// 3x3, 2 for 5x5), then passes the column memory read, window, products, row
// sums and output registers. After the last pixel of a frame, h*W+h drain
// transactions (tuser high) push the remaining results out; tlast marks the
// final result, after which the next transaction starts a new frame. The
// previous rows are held in one column memory of MAX_WIDTH words, read and
// written once per pixel. Configuration should be changed between frames.
module kernel_convolution_2d_top #(
    parameter int MAX_WIDTH  = kc2d_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_KERNEL = kc2d_pkg::DEFAULT_MAX_KERNEL,
    parameter int COEF_BITS  = kc2d_pkg::DEFAULT_COEF_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input pixel stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [kc2d_pkg::PIX_W-1:0]       s_axis_tdata,   // [7:0] pixel_in
    input  logic                             s_axis_tuser,   // [0] mode
    // Result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [kc2d_pkg::PIX_W-1:0]       m_axis_tdata,   // [7:0] pixel_out
    output logic                             m_axis_tlast,   // frame_last
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kc2d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kc2d_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import kc2d_pkg::*;

    localparam int HMAX    = MAX_KERNEL / 2;
    localparam int SPAN    = 2 * HMAX + 1;
    localparam int COL_W   = (SPAN - 1) * PIX_W;
    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int MW      = DIM_W + 1;
    localparam int EXT_W   = COEF_SPAN_W + COEF_BITS;
    localparam int PROD_W  = PIX_W + 1 + COEF_BITS;
    localparam int ROW_W   = PROD_W + $clog2(SPAN);
    localparam int SUM_W   = ROW_W + $clog2(SPAN);
    localparam int RESET_W = (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RESET;
    localparam int RESET_TOTAL = RESET_W * IMAGE_HEIGHT_RESET;

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    logic [DIM_W-1:0]       w_eff_reg;
    logic [DIM_W-1:0]       hgt_eff_reg;
    logic                   large_reg;
    logic [COEF_PAIR_W-1:0] coef_top_reg;
    logic [COEF_PAIR_W-1:0] coef_mid_reg;
    logic [COEF_ROW_W-1:0]  coef_bot_reg;
    logic [CNT_W-1:0]       total_reg;
    logic [DIM_W-1:0]       cfg_w_new;
    logic [DIM_W-1:0]       cfg_h_new;
    logic                   cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb
    begin
        if (cfg_data[DIM_W-1:0] == '0)
        begin
            cfg_w_new = DIM_W'(1);
        end
        else if (int'(cfg_data[DIM_W-1:0]) > MAX_WIDTH)
        begin
            cfg_w_new = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            cfg_w_new = cfg_data[DIM_W-1:0];
        end
        cfg_h_new = (cfg_data[DIM_W-1:0] == '0) ? DIM_W'(1) : cfg_data[DIM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg    <= DIM_W'(RESET_W);
            hgt_eff_reg  <= DIM_W'(IMAGE_HEIGHT_RESET);
            large_reg    <= 1'b0;
            coef_top_reg <= '0;
            coef_mid_reg <= '0;
            coef_bot_reg <= '0;
            total_reg    <= CNT_W'(RESET_TOTAL);
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    w_eff_reg <= cfg_w_new;
                    total_reg <= CNT_W'(cfg_w_new) * CNT_W'(hgt_eff_reg);
                end
                REG_IMAGE_HEIGHT:
                begin
                    hgt_eff_reg <= cfg_h_new;
                    total_reg   <= CNT_W'(w_eff_reg) * CNT_W'(cfg_h_new);
                end
                REG_KERNEL_LARGE:    large_reg    <= cfg_data[0];
                REG_COEF_ROWS_TOP:   coef_top_reg <= cfg_data[COEF_PAIR_W-1:0];
                REG_COEF_ROWS_MID:   coef_mid_reg <= cfg_data[COEF_PAIR_W-1:0];
                REG_COEF_ROW_BOTTOM: coef_bot_reg <= cfg_data[COEF_ROW_W-1:0];
                default:             ;
            endcase
        end
    end

    // The 5x5 kernel needs room for it; otherwise 3x3 is used.
    logic             large_eff;
    logic [MW-1:0]    h_val;
    logic [CNT_W-1:0] w_plus1;
    logic [CNT_W-1:0] lag;
    logic [CNT_W-1:0] last_p;

    assign large_eff = large_reg && (MAX_KERNEL > 3);
    assign h_val     = large_eff ? MW'(HMAX) : MW'(1);
    assign w_plus1   = CNT_W'(w_eff_reg) + CNT_W'(1);
    assign lag       = large_eff ? CNT_W'(HMAX) * w_plus1 : w_plus1;
    assign last_p    = lag + total_reg - CNT_W'(1);

    // Signed coefficients unpacked from the three registers
    logic [EXT_W-1:0]             top_ext;
    logic [EXT_W-1:0]             mid_ext;
    logic [EXT_W-1:0]             bot_ext;
    logic signed [COEF_BITS-1:0]  coef_w [SPAN][SPAN];

    assign top_ext = EXT_W'(coef_top_reg);
    assign mid_ext = EXT_W'(coef_mid_reg);
    assign bot_ext = EXT_W'(coef_bot_reg);

    for (genvar ky = 0; ky < SPAN; ky++)
    begin : g_coef_row
        for (genvar kx = 0; kx < SPAN; kx++)
        begin : g_coef_col
            if (ky < MAX_KERNEL && kx < MAX_KERNEL)
            begin : g_used
                localparam int LANE = (ky < 2) ? ky : ((ky < 4) ? ky - 2 : ky - 4);
                localparam int OFF  = (LANE * MAX_KERNEL + kx) * COEF_BITS;
                logic [EXT_W-1:0] src;
                if (ky < 2)
                begin : g_top
                    assign src = top_ext;
                end
                else if (ky < 4)
                begin : g_mid
                    assign src = mid_ext;
                end
                else
                begin : g_bot
                    assign src = bot_ext;
                end
                if (OFF < COEF_SPAN_W)
                begin : g_in
                    assign coef_w[ky][kx] = $signed(src[OFF +: COEF_BITS]);
                end
                else
                begin : g_out
                    assign coef_w[ky][kx] = '0;
                end
            end
            else
            begin : g_unused
                assign coef_w[ky][kx] = '0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline handshake: each stage moves when the next one is free
    // ------------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic s3_emit_reg, s4_emit_reg;
    logic out_free, s4_move, s4_ready, s3_move, s3_ready;
    logic s2_move, s2_ready, s1_move, s1_ready, in_fire;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign s4_move  = s4_valid_reg && (!s4_emit_reg || out_free);
    assign s4_ready = !s4_valid_reg || s4_move;
    assign s3_move  = s3_valid_reg && s4_ready;
    assign s3_ready = !s3_valid_reg || s3_move;
    assign s2_move  = s2_valid_reg && s3_ready;
    assign s2_ready = !s2_valid_reg || s2_move;
    assign s1_move  = s1_valid_reg && s2_ready;
    assign s1_ready = !s1_valid_reg || s1_move;

    assign s_axis_tready = s1_ready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------------
    // Frame position counters
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0] p_reg, p_next;
    logic [DIM_W-1:0] pc_reg, pc_next;
    logic [MW-1:0]    pr_reg, pr_next;
    logic [DIM_W-1:0] qc_reg, qc_next;
    logic [DIM_W-1:0] qr_reg, qr_next;
    logic             emit_now;
    logic             last_now;

    assign emit_now = (p_reg >= lag) && (p_reg <= last_p);
    assign last_now = (p_reg == last_p);

    always_comb
    begin
        p_next  = p_reg;
        pc_next = pc_reg;
        pr_next = pr_reg;
        qc_next = qc_reg;
        qr_next = qr_reg;
        if (in_fire)
        begin
            if (last_now || p_reg > last_p)
            begin
                // End of frame, or a frame abandoned after a geometry change
                p_next  = '0;
                pc_next = '0;
                pr_next = '0;
                qc_next = '0;
                qr_next = '0;
            end
            else
            begin
                p_next = p_reg + CNT_W'(1);
                if (pc_reg == w_eff_reg - DIM_W'(1))
                begin
                    pc_next = '0;
                    pr_next = pr_reg + MW'(1);
                end
                else
                begin
                    pc_next = pc_reg + DIM_W'(1);
                end
                if (emit_now)
                begin
                    if (qc_reg == w_eff_reg - DIM_W'(1))
                    begin
                        qc_next = '0;
                        qr_next = qr_reg + DIM_W'(1);
                    end
                    else
                    begin
                        qc_next = qc_reg + DIM_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg  <= '0;
            pc_reg <= '0;
            pr_reg <= '0;
            qc_reg <= '0;
            qr_reg <= '0;
        end
        else
        begin
            p_reg  <= p_next;
            pc_reg <= pc_next;
            pr_reg <= pr_next;
            qc_reg <= qc_next;
            qr_reg <= qr_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: pixel and the column of earlier rows read from memory
    // ------------------------------------------------------------------------
    logic [COL_W-1:0]  col_mem [MAX_WIDTH];
    logic [COL_W-1:0]  rd_reg;
    logic              fwd_reg;
    logic [COL_W-1:0]  fwd_data_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [DIM_W-1:0]  s1_pc_reg;
    logic [DIM_W-1:0]  s1_qr_reg;
    logic [DIM_W-1:0]  s1_qc_reg;
    logic              s1_emit_reg;
    logic              s1_last_reg;
    logic [COL_W-1:0]  col_word;
    logic [PIX_W-1:0]  col_full [SPAN];
    logic [COL_W-1:0]  wr_word;
    logic [SPAN-1:0]   rmask;
    logic [SPAN-1:0]   cmask;
    logic              pix_in_frame;

    assign pix_in_frame = !s_axis_tuser && (pr_reg < {1'b0, hgt_eff_reg});

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_reg       <= col_mem[ADDR_W'(pc_reg)];
            fwd_reg      <= s1_move && (s1_pc_reg == pc_reg);
            fwd_data_reg <= wr_word;
            s1_pix_reg   <= pix_in_frame ? s_axis_tdata : '0;
            s1_pc_reg    <= pc_reg;
            s1_qr_reg    <= qr_reg;
            s1_qc_reg    <= qc_reg;
            s1_emit_reg  <= emit_now;
            s1_last_reg  <= last_now;
        end
        if (s1_move)
        begin
            col_mem[ADDR_W'(s1_pc_reg)] <= wr_word;
        end
    end

    // With a one-pixel row the column just written is the one read back.
    assign col_word = fwd_reg ? fwd_data_reg : rd_reg;

    // Entry i of the column is the pixel i rows above the current one.
    assign col_full[0] = s1_pix_reg;
    for (genvar i = 1; i < SPAN; i++)
    begin : g_col
        assign col_full[i] = col_word[(i - 1) * PIX_W +: PIX_W];
    end
    for (genvar i = 0; i < SPAN - 1; i++)
    begin : g_wr
        assign wr_word[i * PIX_W +: PIX_W] = col_full[i];
    end

    // Which kernel rows and columns fall inside the frame
    for (genvar g = 0; g < SPAN; g++)
    begin : g_mask
        logic [MW-1:0] rsum;
        logic [MW-1:0] csum;
        logic          in_kernel;
        assign in_kernel = (g < 3) || (large_eff && (g < MAX_KERNEL));
        assign rsum      = {1'b0, s1_qr_reg} + MW'(g);
        assign csum      = {1'b0, s1_qc_reg} + MW'(g);
        assign rmask[g]  = in_kernel && (rsum >= h_val)
                           && ((rsum - h_val) < {1'b0, hgt_eff_reg});
        assign cmask[g]  = in_kernel && (csum >= h_val)
                           && ((csum - h_val) < {1'b0, w_eff_reg});
    end

    // ------------------------------------------------------------------------
    // Stage 2: window of the most recent columns, newest at age zero
    // ------------------------------------------------------------------------
    logic [PIX_W-1:0] win_reg [SPAN][SPAN];   // [age][rows above]
    logic [SPAN-1:0]  s2_rmask_reg;
    logic [SPAN-1:0]  s2_cmask_reg;
    logic             s2_emit_reg;
    logic             s2_last_reg;

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            for (int r = 0; r < SPAN; r++)
            begin
                win_reg[0][r] <= col_full[r];
                for (int a = 1; a < SPAN; a++)
                begin
                    win_reg[a][r] <= win_reg[a - 1][r];
                end
            end
            s2_rmask_reg <= rmask;
            s2_cmask_reg <= cmask;
            s2_emit_reg  <= s1_emit_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: masked products
    // ------------------------------------------------------------------------
    logic signed [PROD_W-1:0] s3_prod_reg [SPAN][SPAN];
    logic                     s3_last_reg;

    for (genvar ky = 0; ky < SPAN; ky++)
    begin : g_prod_row
        for (genvar kx = 0; kx < SPAN; kx++)
        begin : g_prod_col
            logic [PIX_W-1:0] pix_sel;
            if (ky < 3 && kx < 3)
            begin : g_both
                assign pix_sel = large_eff ? win_reg[2 * HMAX - kx][2 * HMAX - ky]
                                           : win_reg[2 - kx][2 - ky];
            end
            else
            begin : g_large
                assign pix_sel = win_reg[2 * HMAX - kx][2 * HMAX - ky];
            end
            // Both arms are signed so that the coefficient is sign-extended.
            always_ff @(posedge clk)
            begin
                if (s2_move)
                begin
                    s3_prod_reg[ky][kx] <= (s2_rmask_reg[ky] && s2_cmask_reg[kx])
                        ? $signed({1'b0, pix_sel}) * coef_w[ky][kx]
                        : $signed(PROD_W'(0));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            s3_emit_reg <= s2_emit_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: row sums
    // ------------------------------------------------------------------------
    logic signed [ROW_W-1:0] row_sum [SPAN];
    logic signed [ROW_W-1:0] s4_row_reg [SPAN];
    logic                    s4_last_reg;

    always_comb
    begin
        for (int ky = 0; ky < SPAN; ky++)
        begin
            row_sum[ky] = '0;
            for (int kx = 0; kx < SPAN; kx++)
            begin
                row_sum[ky] = row_sum[ky] + ROW_W'(s3_prod_reg[ky][kx]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_move)
        begin
            for (int ky = 0; ky < SPAN; ky++)
            begin
                s4_row_reg[ky] <= row_sum[ky];
            end
            s4_emit_reg <= s3_emit_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Output: total, divide by sixteen rounding toward zero, keep low byte
    // ------------------------------------------------------------------------
    logic signed [SUM_W-1:0] total_sum;
    logic signed [SUM_W-1:0] biased;
    logic signed [SUM_W-1:0] quot;
    logic [PIX_W-1:0]        out_data_reg;
    logic                    out_last_reg;

    always_comb
    begin
        total_sum = '0;
        for (int ky = 0; ky < SPAN; ky++)
        begin
            total_sum = total_sum + SUM_W'(s4_row_reg[ky]);
        end
        biased = total_sum[SUM_W-1] ? total_sum + SUM_W'((1 << DIV_SHIFT) - 1) : total_sum;
        quot   = biased >>> DIV_SHIFT;
    end

    always_ff @(posedge clk)
    begin
        if (s4_move && s4_emit_reg)
        begin
            out_data_reg <= quot[PIX_W-1:0];
            out_last_reg <= s4_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_move)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_move)
            begin
                s3_valid_reg <= 1'b1;
            end
            else if (s3_move)
            begin
                s3_valid_reg <= 1'b0;
            end

            if (s3_move)
            begin
                s4_valid_reg <= 1'b1;
            end
            else if (s4_move)
            begin
                s4_valid_reg <= 1'b0;
            end

            if (s4_move && s4_emit_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> tb/kernel_convolution_2d_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kernel_convolution_2d_top_tb
// Self-checking bench for the streaming 3x3 / 5x5 image convolution.
// ----------------------------------------------------------------------------
// Frames of pixels are streamed in, followed by their drain transactions. A
// behavioural convolution of the frame predicts every result as each input
// transaction is accepted, and a checker compares the result stream against
// those predictions. Geometry and kernels are reprogrammed between frames,
// covering small and extreme sizes, both kernel sizes, degenerate widths and
// heights, drains inside a frame and pixels offered after a frame's pixels.
// ----------------------------------------------------------------------------
module kernel_convolution_2d_top_tb;

    import kc2d_pkg::*;

    localparam int MAX_WIDTH     = DEFAULT_MAX_WIDTH;
    localparam int MAX_KERNEL    = DEFAULT_MAX_KERNEL;
    localparam int COEF_BITS     = DEFAULT_COEF_BITS;
    localparam int LINE_DEPTH    = 4 * MAX_WIDTH + 8;
    localparam int DIVISOR       = 16;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT   = 4000000;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } conv_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [PIX_W-1:0]      m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Mirror of the programmed registers and of the frame being convolved
    logic [DIM_W-1:0]       cfg_width;
    logic [DIM_W-1:0]       cfg_height;
    logic                   cfg_big_kernel;
    logic [COEF_PAIR_W-1:0] cfg_coef_top;
    logic [COEF_PAIR_W-1:0] cfg_coef_mid;
    logic [COEF_ROW_W-1:0]  cfg_coef_bottom;
    logic [PIX_W-1:0]       frame_store [LINE_DEPTH];
    int                     frame_pos;

    logic signed [COEF_BITS-1:0] kernel_plan [MAX_KERNEL][MAX_KERNEL];

    conv_result_t expected_pixels [$];
    conv_result_t checked_pixel;
    int           error_count;
    int           result_count;
    int           items_sent;
    longint       cycle_count;

    int   tx_phase_left;
    bit   tx_quiet;
    int   rx_phase_left;
    bit   rx_quiet;
    int   rx_stall_left;
    int   rx_hold_left;
    logic hold_off_req;

    kernel_convolution_2d_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Most calls give no gap; the others give a gap, now and then a long one.
    function automatic int idle_length(input bit quiet);
        if (quiet || $urandom_range(0, 99) >= 20)
            return 0;
        if ($urandom_range(0, 24) == 0)
            return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Signed coefficient at (row, col) as held in the packed registers.
    function automatic int coef_value(input int row, input int col);
        logic [63:0]          coef_word;
        logic [COEF_BITS-1:0] field;
        int                   lane;
        int                   offset;
        if (row < 2)
        begin
            coef_word = 64'(cfg_coef_top);
            lane = row;
        end
        else if (row < 4)
        begin
            coef_word = 64'(cfg_coef_mid);
            lane = row - 2;
        end
        else
        begin
            coef_word = 64'(cfg_coef_bottom);
            lane = row - 4;
        end
        offset = (lane * MAX_KERNEL + col) * COEF_BITS;
        if (offset >= 64)
            return 0;
        field = COEF_BITS'(coef_word >> offset);
        return int'($signed(field));
    endfunction

    // Convolution of one accepted transaction; queues the result it causes.
    function automatic void predict_convolution(input logic mode_bit,
                                                input logic [PIX_W-1:0] pix);
        int           w;
        int           hgt;
        int           k;
        int           h;
        int           lag;
        int           total;
        int           p;
        int           q;
        int           qr;
        int           qc;
        int           rr;
        int           cc;
        int           sum;
        int           quot;
        conv_result_t res;
        w = cfg_width;
        if (w == 0)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        hgt = (cfg_height == 0) ? 1 : cfg_height;
        k = cfg_big_kernel ? 5 : 3;
        h = k / 2;
        lag = h * w + h;
        total = w * hgt;
        p = frame_pos;
        if (p < total)
            frame_store[p % LINE_DEPTH] = (mode_bit == MODE_DRAIN) ? '0 : pix;
        if (p < lag)
        begin
            frame_pos = p + 1;
            return;
        end
        q = p - lag;
        if (q >= total)
        begin
            frame_pos = 0;
            return;
        end
        qr = q / w;
        qc = q % w;
        sum = 0;
        for (int ky = 0; ky < k; ky++)
        begin
            rr = qr - h + ky;
            if (rr < 0 || rr >= hgt)
                continue;
            for (int kx = 0; kx < k; kx++)
            begin
                cc = qc - h + kx;
                if (cc < 0 || cc >= w)
                    continue;
                sum += int'(frame_store[(rr * w + cc) % LINE_DEPTH]) * coef_value(ky, kx);
            end
        end
        // Integer division truncates toward zero, as required.
        quot = sum / DIVISOR;
        res.pixel = quot[PIX_W-1:0];
        res.last = (q == total - 1);
        expected_pixels.push_back(res);
        frame_pos = res.last ? 0 : p + 1;
    endfunction

    task automatic send_pixel(input logic mode_bit, input logic [PIX_W-1:0] pix);
        int gap;
        if (tx_phase_left == 0)
        begin
            tx_phase_left = $urandom_range(20, 200);
            tx_quiet = ($urandom_range(0, 3) == 0);
        end
        tx_phase_left--;
        gap = idle_length(tx_quiet);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= mode_bit;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_convolution(mode_bit, pix);
        items_sent++;
    endtask

    // Lets every outstanding result come out before the block is touched.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            REG_IMAGE_WIDTH:     cfg_width = value[DIM_W-1:0];
            REG_IMAGE_HEIGHT:    cfg_height = value[DIM_W-1:0];
            REG_KERNEL_LARGE:    cfg_big_kernel = value[0];
            REG_COEF_ROWS_TOP:   cfg_coef_top = value[COEF_PAIR_W-1:0];
            REG_COEF_ROWS_MID:   cfg_coef_mid = value[COEF_PAIR_W-1:0];
            REG_COEF_ROW_BOTTOM: cfg_coef_bottom = value[COEF_ROW_W-1:0];
            default: ;
        endcase
    endtask

    // Programs the geometry and the packed form of kernel_plan.
    task automatic configure(input int width, input int height, input bit big_kernel);
        logic [COEF_PAIR_W-1:0] top_bits;
        logic [COEF_PAIR_W-1:0] mid_bits;
        logic [COEF_ROW_W-1:0]  bottom_bits;
        int                     base;
        wait_idle();
        top_bits = '0;
        mid_bits = '0;
        bottom_bits = '0;
        for (int row = 0; row < MAX_KERNEL; row++)
        begin
            for (int col = 0; col < MAX_KERNEL; col++)
            begin
                base = ((row % 2) * MAX_KERNEL + col) * COEF_BITS;
                if (row < 2)
                    top_bits[base +: COEF_BITS] = kernel_plan[row][col];
                else if (row < 4)
                    mid_bits[base +: COEF_BITS] = kernel_plan[row][col];
                else
                    bottom_bits[base +: COEF_BITS] = kernel_plan[row][col];
            end
        end
        write_register(REG_IMAGE_WIDTH, CFG_DATA_W'(width));
        write_register(REG_IMAGE_HEIGHT, CFG_DATA_W'(height));
        write_register(REG_KERNEL_LARGE, CFG_DATA_W'(big_kernel));
        write_register(REG_COEF_ROWS_TOP, CFG_DATA_W'(top_bits));
        write_register(REG_COEF_ROWS_MID, CFG_DATA_W'(mid_bits));
        write_register(REG_COEF_ROW_BOTTOM, CFG_DATA_W'(bottom_bits));
        cfg_valid <= 1'b0;
    endtask

    task automatic fill_kernel(input int value);
        for (int row = 0; row < MAX_KERNEL; row++)
            for (int col = 0; col < MAX_KERNEL; col++)
                kernel_plan[row][col] = COEF_BITS'(value);
    endtask

    task automatic randomize_kernel();
        int style;
        style = $urandom_range(0, 5);
        for (int row = 0; row < MAX_KERNEL; row++)
        begin
            for (int col = 0; col < MAX_KERNEL; col++)
            begin
                case (style)
                    0:       kernel_plan[row][col] = COEF_BITS'(-16);
                    1:       kernel_plan[row][col] = COEF_BITS'(15);
                    2:       kernel_plan[row][col] = COEF_BITS'($urandom_range(0, 4) - 2);
                    default: kernel_plan[row][col] = COEF_BITS'($urandom_range(0, 31));
                endcase
            end
        end
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Sends a whole frame and its drain; with noise, some pixels become drains
    // and some drain slots carry real pixels instead.
    task automatic send_frame(input int width, input int height, input bit big_kernel,
                              input int noise_pct);
        int   w;
        int   hgt;
        int   h;
        int   total;
        int   lag;
        logic mode_bit;
        w = (width == 0) ? 1 : ((width > MAX_WIDTH) ? MAX_WIDTH : width);
        hgt = (height == 0) ? 1 : height;
        h = big_kernel ? 2 : 1;
        total = w * hgt;
        lag = h * w + h;
        for (int i = 0; i < total + lag; i++)
        begin
            mode_bit = (i >= total) ? MODE_DRAIN : MODE_PIXEL;
            if ($urandom_range(0, 99) < noise_pct)
                mode_bit = ~mode_bit;
            send_pixel(mode_bit, pick_pixel());
        end
    endtask

    task automatic test_small_3x3();
        fill_kernel(0);
        kernel_plan[0][0] = COEF_BITS'(1);
        kernel_plan[0][1] = COEF_BITS'(2);
        kernel_plan[0][2] = COEF_BITS'(1);
        kernel_plan[1][0] = COEF_BITS'(2);
        kernel_plan[1][1] = COEF_BITS'(15);
        kernel_plan[1][2] = COEF_BITS'(2);
        kernel_plan[2][0] = COEF_BITS'(-1);
        kernel_plan[2][1] = COEF_BITS'(-16);
        kernel_plan[2][2] = COEF_BITS'(-1);
        configure(4, 3, 1'b0);
        for (int i = 0; i < 12; i++)
            send_pixel(MODE_PIXEL, (i % 3 == 0) ? 8'hFF : PIX_W'(i * 23));
        for (int i = 0; i < 5; i++)
            send_pixel(MODE_DRAIN, 8'hA5);
    endtask

    // A drain inside the frame reads as a zero pixel, and a real pixel offered
    // after the frame's pixels is taken as a drain.
    task automatic test_5x5_drain_cases();
        fill_kernel(-16);
        kernel_plan[2][2] = COEF_BITS'(15);
        kernel_plan[4][4] = COEF_BITS'(15);
        configure(3, 3, 1'b1);
        for (int i = 0; i < 9; i++)
            send_pixel((i == 4) ? MODE_DRAIN : MODE_PIXEL, 8'hFF);
        for (int i = 0; i < 8; i++)
            send_pixel((i == 1 || i == 5) ? MODE_PIXEL : MODE_DRAIN, 8'hFF);
    endtask

    // Zero width and zero height both act as one.
    task automatic test_degenerate_sizes();
        fill_kernel(15);
        configure(0, 0, 1'b1);
        send_frame(0, 0, 1'b1, 0);
        randomize_kernel();
        configure(0, 5, 1'b0);
        send_frame(0, 5, 1'b0, 0);
        configure(1, 1, 1'b0);
        send_frame(1, 1, 1'b0, 0);
    endtask

    // Width above the line capacity is clamped; height has no such clamp.
    task automatic test_max_geometry();
        randomize_kernel();
        configure(1023, 1, 1'b1);
        send_frame(1023, 1, 1'b1, 0);
        randomize_kernel();
        configure(1, 1023, 1'b0);
        send_frame(1, 1023, 1'b0, 5);
    endtask

    // The receiver holds off long enough for the block to fill and push back.
    task automatic test_backpressure();
        randomize_kernel();
        configure(24, 12, 1'b1);
        hold_off_req <= 1'b1;
        @(posedge clk);
        hold_off_req <= 1'b0;
        send_frame(24, 12, 1'b1, 0);
    endtask

    task automatic test_random_frames();
        int first_item;
        int width;
        int height;
        int sel;
        bit big_kernel;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 29);
            if (sel == 0)
            begin
                width = $urandom_range(64, MAX_WIDTH);
                height = 1;
            end
            else if (sel < 3)
            begin
                width = $urandom_range(0, 1);
                height = $urandom_range(0, 30);
            end
            else
            begin
                width = $urandom_range(1, 24);
                height = $urandom_range(1, 12);
            end
            big_kernel = 1'($urandom_range(0, 1));
            randomize_kernel();
            configure(width, height, big_kernel);
            send_frame(width, height, big_kernel, ($urandom_range(0, 3) == 0) ? 10 : 0);
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_off_req)
            rx_hold_left = HOLD_OFF_CYCLES;
        if (rx_phase_left == 0)
        begin
            rx_phase_left = $urandom_range(30, 300);
            rx_quiet = ($urandom_range(0, 3) == 0);
        end
        rx_phase_left--;
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            rx_stall_left = idle_length(rx_quiet);
            m_axis_tready <= (rx_stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            result_count++;
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %02h, last %0b",
                                          m_axis_tdata, m_axis_tlast));
            end
            else
            begin
                checked_pixel = expected_pixels.pop_front();
                if (m_axis_tdata !== checked_pixel.pixel)
                    report_mismatch($sformatf("result %0d: pixel_out %02h, wanted %02h",
                                              result_count, m_axis_tdata,
                                              checked_pixel.pixel));
                if (m_axis_tlast !== checked_pixel.last)
                    report_mismatch($sformatf("result %0d: frame_last %0b, wanted %0b",
                                              result_count, m_axis_tlast,
                                              checked_pixel.last));
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_PIXEL;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data = '0;
        hold_off_req = 1'b0;
        error_count = 0;
        result_count = 0;
        items_sent = 0;
        cycle_count = 0;
        tx_phase_left = 0;
        rx_phase_left = 0;
        rx_stall_left = 0;
        rx_hold_left = 0;
        cfg_width = DIM_W'(IMAGE_WIDTH_RESET);
        cfg_height = DIM_W'(IMAGE_HEIGHT_RESET);
        cfg_big_kernel = 1'b0;
        cfg_coef_top = '0;
        cfg_coef_mid = '0;
        cfg_coef_bottom = '0;
        frame_pos = 0;
        for (int i = 0; i < LINE_DEPTH; i++)
            frame_store[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_small_3x3();
        test_5x5_drain_cases();
        test_degenerate_sizes();
        test_max_geometry();
        test_backpressure();
        test_random_frames();

        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> kernel_convolution_2d_top.f
src/kc2d_pkg.sv
src/kernel_convolution_2d_top.sv
tb/kernel_convolution_2d_top_tb.sv
